FILE: rtl/ray_cylinder_intersection_assert.svh
// Assertion helpers, sampled on clk_i and disabled while rst_ni is low.
`ifndef RAY_CYLINDER_INTERSECTION_ASSERT_SVH
`define RAY_CYLINDER_INTERSECTION_ASSERT_SVH
`ifndef SYNTHESIS
`define RCI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define RCI_ASSERT_IMP(lbl, ante, cons) \
  `RCI_ASSERT(lbl, (ante) |-> (cons))
`define RCI_ASSERT_NXT(lbl, ante, cons) \
  `RCI_ASSERT(lbl, (ante) |=> (cons))
`else
`define RCI_ASSERT(lbl, prop)
`define RCI_ASSERT_IMP(lbl, ante, cons)
`define RCI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/rci_pkg.sv
package rci_pkg;

  localparam int CoordW   = 16;
  localparam int RadiusW  = 15;
  localparam int SqSteps  = 31;   // root bits of a 62-bit radicand
  localparam int RadW     = 2 * SqSteps;
  localparam int RemW     = SqSteps + 4;
  localparam int DivSteps = 17;   // quotient bits below the saturation bound
  localparam int NumW     = 33;   // magnitude of s - bh
  localparam int ProdW    = CoordW + NumW;
  localparam logic [RadiusW-1:0] RadiusReset = RadiusW'(256);

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_NO_ROOT  = 2'd1,
    ST_PARALLEL = 2'd2
  } status_e;

  typedef struct packed {
    coord_t [2:0]       dir;
    coord_t [2:0]       org;
    logic [31:0]        a;
    logic signed [32:0] bh;
    status_e            status;
  } ctx_t;

endpackage

FILE: rtl/ray_cylinder_intersection.sv
// Ray versus infinite cylinder (axis = z) intersection, larger root.
// Slave channel: one ray per beat, s_axis_tdata = dir_x, dir_y, dir_z, org_x,
// org_y, org_z (signed Q8.8, 16 bits each, dir_x lowest).
// Master channel: hit_x, hit_y, hit_z in m_axis_tdata (lowest first) and the
// status in m_axis_tuser: 0 hit, 1 no real root, 2 direction parallel to z.
// Flagged beats carry a zero point.
// Radius: unsigned Q7.8, written through cfg_wen_i / cfg_wdata_i while idle.
// Throughput: one beat per cycle unless the output stalls; the square root is a 31-stage digit
// pipeline and the divide a 17-stage restoring pipeline per component.
// The whole pipe advances together; when the output beat is held by
// m_axis_tready_i low, s_axis_tready_o drops and every stage freezes.
// Reset empties the pipe and loads radius 1.0.
`include "ray_cylinder_intersection_assert.svh"

module ray_cylinder_intersection (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wen_i,
  input  logic [14:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // dir_x, dir_y, dir_z, org_x, org_y, org_z
  input  logic [95:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // hit_x, hit_y, hit_z
  output logic [47:0] m_axis_tdata_o,
  // status
  output logic [1:0]  m_axis_tuser_o
);

  localparam int SQ = rci_pkg::SqSteps;
  localparam int DV = rci_pkg::DivSteps;

  logic adv;
  logic out_v_q;
  assign adv             = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // radius and its square
  logic [rci_pkg::RadiusW-1:0]   radius_q;
  logic [2*rci_pkg::RadiusW-1:0] r2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= rci_pkg::RadiusReset;
      r2_q     <= rci_pkg::RadiusReset * rci_pkg::RadiusReset;
    end else begin
      if (cfg_wen_i) radius_q <= cfg_wdata_i;
      r2_q <= radius_q * radius_q;
    end
  end

  // stage 1: products
  rci_pkg::coord_t in_dir [3];
  rci_pkg::coord_t in_org [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_dir[k] = $signed(s_axis_tdata_i[16*k +: 16]);
      in_org[k] = $signed(s_axis_tdata_i[48 + 16*k +: 16]);
    end
  end

  logic v1_q;
  logic signed [31:0] xx_q, yy_q, xox_q, yoy_q, xoy_q, yox_q;
  rci_pkg::ctx_t ctx1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      xx_q  <= in_dir[0] * in_dir[0];
      yy_q  <= in_dir[1] * in_dir[1];
      xox_q <= in_dir[0] * in_org[0];
      yoy_q <= in_dir[1] * in_org[1];
      xoy_q <= in_dir[0] * in_org[1];
      yox_q <= in_dir[1] * in_org[0];
      for (int k = 0; k < 3; k++) begin
        ctx1_q.dir[k] <= in_dir[k];
        ctx1_q.org[k] <= in_org[k];
      end
      ctx1_q.a      <= '0;
      ctx1_q.bh     <= '0;
      ctx1_q.status <= rci_pkg::ST_HIT;
    end
  end

  // stage 2: a, b/2, cross term
  logic [31:0]        a_d;
  logic signed [32:0] bh_d, cr_d, cr_neg;
  logic [31:0]        crm_d;
  rci_pkg::ctx_t      ctx2_d;
  always_comb begin
    a_d    = $unsigned(xx_q) + $unsigned(yy_q);
    bh_d   = {xox_q[31], xox_q} + {yoy_q[31], yoy_q};
    cr_d   = {xoy_q[31], xoy_q} - {yox_q[31], yox_q};
    cr_neg = -cr_d;
    crm_d  = cr_d[32] ? cr_neg[31:0] : cr_d[31:0];
    ctx2_d        = ctx1_q;
    ctx2_d.a      = a_d;
    ctx2_d.bh     = bh_d;
    ctx2_d.status = (a_d == '0) ? rci_pkg::ST_PARALLEL : rci_pkg::ST_HIT;
  end

  logic v2_q;
  logic [31:0] crm_q;
  rci_pkg::ctx_t ctx2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      crm_q  <= crm_d;
      ctx2_q <= ctx2_d;
    end
  end

  // stage 3: a*R^2 and cr^2
  logic v3_q;
  logic [61:0] ar2_q;
  logic [63:0] cr2_q;
  rci_pkg::ctx_t ctx3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ar2_q  <= ctx2_q.a * r2_q;
      cr2_q  <= crm_q * crm_q;
      ctx3_q <= ctx2_q;
    end
  end

  // stage 4 (sqrt index 0): quarter discriminant
  logic [64:0] disc_d;
  assign disc_d = {3'b000, ar2_q} - {1'b0, cr2_q};

  rci_pkg::ctx_t sq_ctx_d;
  always_comb begin
    sq_ctx_d = ctx3_q;
    if (ctx3_q.status == rci_pkg::ST_HIT && disc_d[64]) sq_ctx_d.status = rci_pkg::ST_NO_ROOT;
  end

  logic [SQ:0]                  sq_v_q;
  logic [SQ-1:0]                sq_root_q [SQ+1];
  logic [rci_pkg::RemW-1:0]     sq_rem_q  [SQ+1];
  logic [rci_pkg::RadW-1:0]     sq_rad_q  [SQ+1];
  rci_pkg::ctx_t                sq_ctx_q  [SQ+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_root_q[0] <= '0;
      sq_rem_q[0]  <= '0;
      sq_rad_q[0]  <= disc_d[rci_pkg::RadW-1:0];
      sq_ctx_q[0]  <= sq_ctx_d;
    end
  end

  // digit-by-digit square root, one root bit per stage
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [rci_pkg::RemW-1:0] r4, trial;
    always_comb begin
      r4    = {sq_rem_q[k][rci_pkg::RemW-3:0], sq_rad_q[k][rci_pkg::RadW-1 -: 2]};
      trial = {{(rci_pkg::RemW-SQ-2){1'b0}}, sq_root_q[k], 2'b01};
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (r4 >= trial) begin
          sq_rem_q[k+1]  <= r4 - trial;
          sq_root_q[k+1] <= {sq_root_q[k][SQ-2:0], 1'b1};
        end else begin
          sq_rem_q[k+1]  <= r4;
          sq_root_q[k+1] <= {sq_root_q[k][SQ-2:0], 1'b0};
        end
        sq_rad_q[k+1] <= {sq_rad_q[k][rci_pkg::RadW-3:0], 2'b00};
        sq_ctx_q[k+1] <= sq_ctx_q[k];
      end
    end
  end

  // stage 5: numerator s - bh
  logic signed [rci_pkg::NumW:0] num_d, num_ng;
  assign num_d  = {{(rci_pkg::NumW+1-SQ){1'b0}}, sq_root_q[SQ]}
                  - {sq_ctx_q[SQ].bh[32], sq_ctx_q[SQ].bh};
  assign num_ng = -num_d;

  logic v5_q;
  logic                      nneg_q;
  logic [rci_pkg::NumW-1:0]  nmag_q;
  rci_pkg::ctx_t             ctx5_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nneg_q <= num_d[rci_pkg::NumW];
      nmag_q <= num_d[rci_pkg::NumW] ? num_ng[rci_pkg::NumW-1:0]
                                     : num_d[rci_pkg::NumW-1:0];
      ctx5_q <= sq_ctx_q[SQ];
    end
  end

  // stage 6: |dk| * |num| per lane
  logic v6_q;
  logic [rci_pkg::ProdW-1:0] prod_q [3];
  logic [2:0]                neg6_q;
  rci_pkg::ctx_t             ctx6_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        prod_q[l] <= (ctx5_q.dir[l][15] ? 16'(-ctx5_q.dir[l]) : 16'(ctx5_q.dir[l]))
                     * nmag_q;
        neg6_q[l] <= ctx5_q.dir[l][15] ^ nneg_q;
      end
      ctx6_q <= ctx5_q;
    end
  end

  // stage 7 (div index 0): saturation bound and remainder seed
  logic [DV:0]    dv_v_q;
  logic [31:0]    dv_rem_q [DV+1][3];
  logic [DV-1:0]  dv_low_q [DV+1][3];
  logic [DV-1:0]  dv_quo_q [DV+1][3];
  logic [2:0]     dv_neg_q [DV+1];
  logic [2:0]     dv_sat_q [DV+1];
  rci_pkg::ctx_t  dv_ctx_q [DV+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        dv_rem_q[0][l] <= prod_q[l][rci_pkg::ProdW-1:DV];
        dv_low_q[0][l] <= prod_q[l][DV-1:0];
        dv_quo_q[0][l] <= '0;
        dv_sat_q[0][l] <= (prod_q[l][rci_pkg::ProdW-1:DV] >= ctx6_q.a);
      end
      dv_neg_q[0] <= neg6_q;
      dv_ctx_q[0] <= ctx6_q;
    end
  end

  // restoring division, one quotient bit per stage and lane
  for (genvar j = 0; j < DV; j++) begin : g_div
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [32:0] r;
      assign r = {dv_rem_q[j][l], dv_low_q[j][l][DV-1]};
      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (r >= {1'b0, dv_ctx_q[j].a}) begin
            dv_rem_q[j+1][l] <= 32'(r - {1'b0, dv_ctx_q[j].a});
            dv_quo_q[j+1][l] <= {dv_quo_q[j][l][DV-2:0], 1'b1};
          end else begin
            dv_rem_q[j+1][l] <= r[31:0];
            dv_quo_q[j+1][l] <= {dv_quo_q[j][l][DV-2:0], 1'b0};
          end
          dv_low_q[j+1][l] <= {dv_low_q[j][l][DV-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_neg_q[j+1] <= dv_neg_q[j];
        dv_sat_q[j+1] <= dv_sat_q[j];
        dv_ctx_q[j+1] <= dv_ctx_q[j];
      end
    end
  end

  // output stage: round half up on the magnitude, add origin, saturate
  localparam logic signed [18:0] MaxV = 19'sd32767;
  localparam logic signed [18:0] MinV = -19'sd32768;

  rci_pkg::coord_t   hit_d [3];
  logic [DV:0]       qr    [3];
  logic signed [18:0] sum  [3];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qr[l]  = {1'b0, dv_quo_q[DV][l]}
               + (DV+1)'({dv_rem_q[DV][l], 1'b0} >= {1'b0, dv_ctx_q[DV].a});
      sum[l] = dv_neg_q[DV][l]
               ? {{3{dv_ctx_q[DV].org[l][15]}}, dv_ctx_q[DV].org[l]} - {1'b0, qr[l]}
               : {{3{dv_ctx_q[DV].org[l][15]}}, dv_ctx_q[DV].org[l]} + {1'b0, qr[l]};
      if (dv_ctx_q[DV].status != rci_pkg::ST_HIT) begin
        hit_d[l] = '0;
      end else if (dv_sat_q[DV][l]) begin
        hit_d[l] = dv_neg_q[DV][l] ? 16'(MinV) : 16'(MaxV);
      end else if (sum[l] > MaxV) begin
        hit_d[l] = 16'(MaxV);
      end else if (sum[l] < MinV) begin
        hit_d[l] = 16'(MinV);
      end else begin
        hit_d[l] = 16'(sum[l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata_o <= {hit_d[2], hit_d[1], hit_d[0]};
      m_axis_tuser_o <= dv_ctx_q[DV].status;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      sq_v_q  <= '0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      dv_v_q  <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v1_q    <= s_axis_tvalid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      sq_v_q  <= {sq_v_q[SQ-1:0], v3_q};
      v5_q    <= sq_v_q[SQ];
      v6_q    <= v5_q;
      dv_v_q  <= {dv_v_q[DV-1:0], v6_q};
      out_v_q <= dv_v_q[DV];
    end
  end

  assign m_axis_tvalid_o = out_v_q;

  `RCI_ASSERT_NXT(a_accept_enters, s_axis_tvalid_i && s_axis_tready_o, v1_q)
  `RCI_ASSERT_NXT(a_stall_freezes, !adv,
                  $stable(sq_v_q) && $stable(dv_v_q) && $stable(v1_q))
  `RCI_ASSERT_IMP(a_flag_zero, m_axis_tvalid_o && m_axis_tuser_o != rci_pkg::ST_HIT,
                  m_axis_tdata_o == '0)
  `RCI_ASSERT_IMP(a_r2_tracks, !$past(cfg_wen_i), r2_q == radius_q * radius_q)

endmodule

FILE: tb/tb_ray_cylinder_intersection.sv
`timescale 1ns / 100ps

module tb_ray_cylinder_intersection;

  typedef struct packed {
    rci_pkg::coord_t  hx;
    rci_pkg::coord_t  hy;
    rci_pkg::coord_t  hz;
    rci_pkg::status_e st;
  } hit_t;

  localparam int LatencyCycles = 56;
  localparam int CycleLimit    = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wen = 1'b0;
  logic [14:0] cfg_wdata = '0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [95:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [47:0] m_data;
  logic [1:0]  m_user;

  ray_cylinder_intersection i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wen_i       (cfg_wen),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [95:0] ray_queue[$];
  hit_t        hit_queue[$];
  logic [14:0] radius = 15'd256;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  bit          in_beat = 1'b0;
  int          errors = 0;
  int          cycles = 0;

  function automatic logic [127:0] mag128(longint v);
    return v < 0 ? 128'(-v) : 128'(v);
  endfunction

  // ok + round(dk * num / a), rounding half away from zero, saturated
  function automatic rci_pkg::coord_t hit_coord(longint dk, longint ok, longint num,
                                                longint a);
    logic [127:0] prod, q, rem;
    longint       sum;
    bit           neg;
    prod = mag128(dk) * mag128(num);
    q    = prod / 128'(a);
    rem  = prod % 128'(a);
    if (rem * 2 >= 128'(a)) q = q + 1;
    neg = (dk < 0) != (num < 0);
    if (q >= (128'(1) << 40))
      return neg ? rci_pkg::coord_t'(-32768) : rci_pkg::coord_t'(32767);
    sum = neg ? ok - longint'(q[63:0]) : ok + longint'(q[63:0]);
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    return rci_pkg::coord_t'(sum);
  endfunction

  function automatic hit_t predict_hit(logic [95:0] ray, logic [14:0] rad);
    longint       c[6];
    longint       a, bh, cr, num;
    logic [127:0] ar2, cr2, disc, root, cand;
    hit_t         h;
    for (int k = 0; k < 6; k++) c[k] = longint'($signed(ray[16*k +: 16]));
    h = '{hx: '0, hy: '0, hz: '0, st: rci_pkg::ST_HIT};
    a = c[0] * c[0] + c[1] * c[1];
    if (a == 0) begin
      h.st = rci_pkg::ST_PARALLEL;
      return h;
    end
    bh  = c[0] * c[3] + c[1] * c[4];
    cr  = c[0] * c[4] - c[1] * c[3];
    ar2 = 128'(a) * 128'(rad) * 128'(rad);
    cr2 = mag128(cr) * mag128(cr);
    if (cr2 > ar2) begin
      h.st = rci_pkg::ST_NO_ROOT;
      return h;
    end
    disc = ar2 - cr2;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (128'(1) << b);
      if (cand * cand <= disc) root = cand;
    end
    num  = longint'(root[63:0]) - bh;
    h.hx = hit_coord(c[0], c[3], num, a);
    h.hy = hit_coord(c[1], c[4], num, a);
    h.hz = hit_coord(c[2], c[5], num, a);
    return h;
  endfunction

  function automatic logic [95:0] pack_ray(int dx, int dy, int dz, int ox, int oy, int oz);
    return {16'(oz), 16'(oy), 16'(ox), 16'(dz), 16'(dy), 16'(dx)};
  endfunction

  function automatic int rnd16();
    return int'($signed(16'($urandom)));
  endfunction

  function automatic int rnd_span(int lim);
    return $urandom_range(2 * lim) - lim;
  endfunction

  // mostly rays whose origin lies near the cylinder so roots exist
  function automatic logic [95:0] random_ray(int rad);
    int lim, dl;
    lim = rad + 64;
    if (lim > 32767) lim = 32767;
    dl = ($urandom_range(1)) ? 1024 : 32767;
    if ($urandom_range(9) < 7)
      return pack_ray(rnd_span(dl), rnd_span(dl), rnd16(), rnd_span(lim), rnd_span(lim),
                      rnd16());
    return 96'({$urandom, $urandom, $urandom});
  endfunction

  // input driver
  always @(negedge clk_i) begin
    int gap;
    logic next_valid;
    next_valid = s_valid;
    if (rst_ni && !(s_valid && !in_beat)) begin
      if (gap > 0) begin
        gap--;
        next_valid = 1'b0;
      end else if (ray_queue.size() == 0) begin
        next_valid = 1'b0;
      end else if (!quiet && $urandom_range(7) == 0) begin
        gap = $urandom_range(5, 1) - 1;
        next_valid = 1'b0;
      end else begin
        s_data <= ray_queue.pop_front();
        next_valid = 1'b1;
      end
    end
    s_valid <= next_valid;
  end

  // output receiver
  always @(negedge clk_i) begin
    int stall;
    logic next_ready;
    next_ready = 1'b1;
    if (hold_req) stall = 300;
    if (!rst_ni) begin
      next_ready = 1'b0;
    end else if (stall > 0) begin
      stall--;
      next_ready = 1'b0;
    end else if (!quiet && $urandom_range(7) == 0) begin
      stall = $urandom_range(5, 1) - 1;
      next_ready = 1'b0;
    end
    m_ready <= next_ready;
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin
    hit_t got, want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      in_beat = s_valid && s_ready && rst_ni;
      if (in_beat) hit_queue.push_back(predict_hit(s_data, radius));
      if (rst_ni && m_valid && m_ready) begin
        got = '{hx: m_data[15:0], hy: m_data[31:16], hz: m_data[47:32],
                st: rci_pkg::status_e'(m_user)};
        if (hit_queue.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, got);
          errors++;
        end else begin
          want = hit_queue.pop_front();
          if (got.hx !== want.hx) begin
            $display("%0t: hit_x exp %h act %h", $time, want.hx, got.hx);
            errors++;
          end
          if (got.hy !== want.hy) begin
            $display("%0t: hit_y exp %h act %h", $time, want.hy, got.hy);
            errors++;
          end
          if (got.hz !== want.hz) begin
            $display("%0t: hit_z exp %h act %h", $time, want.hz, got.hz);
            errors++;
          end
          if (got.st !== want.st) begin
            $display("%0t: status exp %0d act %0d", $time, want.st, got.st);
            errors++;
          end
        end
      end
    end
  end

  task automatic drain();
    while (ray_queue.size() != 0 || s_valid || hit_queue.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 4) @(posedge clk_i);
  endtask

  task automatic set_radius(logic [14:0] value);
    @(negedge clk_i);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    radius     = value;
    @(negedge clk_i);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    logic [14:0] phase_radius[6];
    phase_radius = '{15'd256, 15'd0, 15'd32767, 15'd1, 15'($urandom), 15'd4096};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset radius 1.0, before any write
    ray_queue.push_back(pack_ray(0, 0, 256, 100, 100, 5));          // parallel to axis
    ray_queue.push_back(pack_ray(0, 0, -32768, -32768, 32767, 0));
    ray_queue.push_back(pack_ray(256, 0, 0, 0, 0, 0));              // origin on axis
    ray_queue.push_back(pack_ray(256, 0, 0, 0, 256, 0));            // tangent, zero disc
    ray_queue.push_back(pack_ray(256, 0, 0, 0, 512, 0));            // miss
    ray_queue.push_back(pack_ray(1, 0, 32767, 0, 0, 0));            // z saturates high
    ray_queue.push_back(pack_ray(-1, 0, 32767, 0, 0, -32768));      // z saturates
    ray_queue.push_back(pack_ray(32767, 32767, 32767, 32767, 32767, 32767));
    ray_queue.push_back(pack_ray(-32768, -32768, -32768, -32768, -32768, -32768));
    ray_queue.push_back(pack_ray(-32768, 32767, 0, 0, 0, 0));
    ray_queue.push_back(pack_ray(0, 1, 0, 0, 0, 0));
    ray_queue.push_back(pack_ray(1, 1, -1, -1, -1, -1));
    ray_queue.push_back(pack_ray(-256, 0, 0, 300, 0, 0));
    ray_queue.push_back(pack_ray(0, -128, 77, 0, -200, 9));
    drain();

    for (int p = 0; p < 6; p++) begin
      set_radius(phase_radius[p]);
      quiet = (p == 5);
      ray_queue.push_back(pack_ray(256, 0, 0, 0, 0, 0));
      ray_queue.push_back(pack_ray(0, 0, 1, 0, 0, 0));
      for (int n = 0; n < 70; n++) ray_queue.push_back(random_ray(phase_radius[p]));
      if (p == 2) begin
        // held until the receiver has sampled it at a falling edge
        hold_req = 1'b1;
        repeat (2) @(negedge clk_i);
        hold_req = 1'b0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
